/* hw/rtl/ipf_pkg.sv */
// shared types, constants and crc helper for the i/q packet framer
package ipf_pkg;

    localparam int MAX_SAMPLES_DEF = 32;
    localparam int FRAME_BYTES     = 14;
    localparam int SAMPLE_BYTES    = 4;
    localparam int SAMPLE_CRC_BYTES = 6;
    localparam int LEN_W           = 4;

    localparam logic [7:0]  SYNC_0       = 8'hAA;
    localparam logic [7:0]  SYNC_1       = 8'h55;
    localparam logic [7:0]  MARKER_RESET = 8'd212;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_TOP      = 16'h8000;

    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic REG_MARKER = 1'b0;

    typedef struct packed {
        logic        action;
        logic [15:0] seq_num;
        logic [31:0] first_index;
        logic [7:0]  num_samples;
        logic [31:0] drop_count;
        logic [15:0] i_value;
        logic [15:0] q_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic                     is_header;
        logic [LEN_W-1:0]         len;
        logic [FRAME_BYTES*8-1:0] data;
    } frame_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/iq_packet_framer_crc16.sv */
// top level of the i/q packet framer with crc16-ccitt trailer
//
// input channel (in_valid, in_stall, in_item): header items open a packet,
// sample items carry one i/q pair. an item is taken when in_valid is high and
// in_stall is low. headers with a bad sample count and samples with no open
// packet are taken and give no output.
// output channel (out_valid, out_stall, out_item): one packet byte per item,
// last_of_run marks the final byte of one input item, end_of_packet marks the
// crc high byte.
// an accepted item is framed into an input register, moved into the byte
// sequencer, and its first byte is then loaded into the output register.
// the output register sends one byte per cycle while out_stall is low; a
// header is 14 bytes long, a sample 4 and a closing sample 6, and the next
// item is taken while the current one is still being sent.
// the crc is advanced by one byte per cycle as covered bytes are sent, unless stalled.
// when out_stall is high the output byte holds and the sequencer waits;
// while the input register is full and cannot move on, in_stall is high.
// reset empties all stages, closes any packet and sets the marker to 0xd4.
module iq_packet_framer_crc16 #(
    parameter int MAX_SAMPLES = ipf_pkg::MAX_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ipf_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output ipf_pkg::out_item_t out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ipf_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [7:0] MAX_CNT = 8'(MAX_SAMPLES);

    logic [7:0]       marker_reg;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             pend_valid_reg;
    frame_t           pend_reg, pend_next;
    logic             ser_valid_reg;
    frame_t           ser_reg;
    logic [LEN_W-1:0] idx_reg;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg;
    out_item_t        out_reg, out_next;

    logic in_take, emit, pend_take, out_load, ser_last, covered;
    logic [7:0] cur_byte;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MARKER) ? {24'd0, marker_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_MARKER)
        begin
            marker_reg <= pwdata[7:0];
        end
    end

    // framing at the input
    assign out_load  = ser_valid_reg && (!out_valid_reg || !out_stall);
    assign ser_last  = (idx_reg == ser_reg.len - LEN_W'(1));
    assign pend_take = pend_valid_reg && (!ser_valid_reg || (out_load && ser_last));
    assign in_stall  = pend_valid_reg && !pend_take;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        left_next = left_reg;
        emit      = 1'b0;
        pend_next = pend_reg;
        if (in_item.action == ACT_HEADER)
        begin
            left_next = '0;
            pend_next.is_header = 1'b1;
            pend_next.len       = LEN_W'(FRAME_BYTES);
            pend_next.data      = {in_item.drop_count, in_item.num_samples,
                                   in_item.first_index, in_item.seq_num,
                                   marker_reg, SYNC_1, SYNC_0};
            if (in_item.num_samples != 8'd0 && in_item.num_samples <= MAX_CNT)
            begin
                emit      = 1'b1;
                left_next = in_item.num_samples[CNT_W-1:0];
            end
        end
        else if (left_reg != '0)
        begin
            emit      = 1'b1;
            left_next = left_reg - CNT_W'(1);
            pend_next.is_header = 1'b0;
            pend_next.len       = (left_reg == CNT_W'(1)) ? LEN_W'(SAMPLE_CRC_BYTES)
                                                          : LEN_W'(SAMPLE_BYTES);
            pend_next.data      = {{(FRAME_BYTES*8-32){1'b0}},
                                   in_item.q_value, in_item.i_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                left_reg <= left_next;
            end
            if (in_take && emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_take)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && emit)
        begin
            pend_reg <= pend_next;
        end
    end

    // byte sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pend_take)
        begin
            ser_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_load)
        begin
            if (ser_last)
            begin
                ser_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_take)
        begin
            ser_reg <= pend_reg;
        end
    end

    always_comb
    begin
        cur_byte = ser_reg.data[{idx_reg, 3'b000} +: 8];
        covered  = ser_reg.is_header ? (idx_reg >= LEN_W'(2))
                                     : (idx_reg < LEN_W'(SAMPLE_BYTES));
        out_next.end_of_packet = 1'b0;
        out_next.last_of_run   = ser_last;
        if (!ser_reg.is_header && idx_reg == LEN_W'(SAMPLE_BYTES))
        begin
            cur_byte = crc_reg[7:0];
        end
        else if (!ser_reg.is_header && idx_reg == LEN_W'(SAMPLE_BYTES + 1))
        begin
            cur_byte = crc_reg[15:8];
            out_next.end_of_packet = 1'b1;
        end
        out_next.out_byte = cur_byte;

        crc_next = crc_reg;
        if (out_load)
        begin
            if (ser_reg.is_header && idx_reg == '0)
            begin
                crc_next = CRC_INIT;
            end
            else if (covered)
            begin
                crc_next = crc_feed(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // checks
    a_eop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.end_of_packet |-> out_reg.last_of_run)
        else $error("end of packet without last of run");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> idx_reg < ser_reg.len)
        else $error("sequencer index beyond frame");

    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !ser_valid_reg |=> ser_valid_reg)
        else $error("framed item not moved into sequencer");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && ser_reg.is_header && idx_reg == '0 |=> crc_reg == CRC_INIT)
        else $error("crc not restarted at header");

    a_stall_holds_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> pend_valid_reg)
        else $error("input register emptied while stalled");

endmodule
